[rtl/bbme_pkg.sv]
`timescale 1ns / 1ps
package bbme_pkg;

    // field widths
    localparam int MASS_W = 32;
    localparam int COEF_W = 32;
    localparam int DENS_W = 40;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // degree of the polynomial
    localparam int DEGREE_DEF = 3;
    localparam int MAX_DEGREE = 3;

    // kallen product and its square root
    localparam int RAD_W  = 132;
    localparam int ROOT_W = RAD_W / 2;

    // Q0.30 fractions, one bit of headroom for the value one
    localparam int FRAC_W = 30;
    localparam int UNIT_W = FRAC_W + 1;
    localparam logic [UNIT_W-1:0] ONE_Q30  = UNIT_W'(1) << FRAC_W;
    localparam logic [UNIT_W-1:0] HALF_Q30 = UNIT_W'(1) << (FRAC_W - 1);

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_MASS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY_RANGE = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MASS_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_MASS_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_Q_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_Q_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_0 = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_1 = 3'd5;
    localparam logic [IDX_W-1:0] REG_COEF_2 = 3'd6;
    localparam logic [IDX_W-1:0] REG_COEF_3 = 3'd7;

    // t selection after the range compare
    localparam logic [1:0] TSEL_DIV  = 2'd0;
    localparam logic [1:0] TSEL_ZERO = 2'd1;
    localparam logic [1:0] TSEL_ONE  = 2'd2;

    // binomial coefficient for degrees up to three
    function automatic logic [1:0] binom(input int n, input int k);
        logic [1:0] r;
        if (k < 0 || k > n) begin
            r = 2'd0;
        end else if (k == 0 || k == n) begin
            r = 2'd1;
        end else if (n == 2) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

endpackage

[rtl/bbme_sqrt.sv]
`timescale 1ns / 1ps
module bbme_sqrt #(
    parameter int RAD_W  = 132,
    parameter int SIDE_W = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [RAD_W/2-1:0]  out_root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int RW = RAD_W / 2;
    localparam int MW = RW + 2;

    logic              val_reg  [0:RW];
    logic [SIDE_W-1:0] side_reg [0:RW];
    logic [RAD_W-1:0]  rad_reg  [0:RW];
    logic [MW-1:0]     rem_reg  [0:RW];
    logic [RW-1:0]     root_reg [0:RW];

    logic [MW+1:0] try_c   [1:RW];
    logic [MW+1:0] trial_c [1:RW];
    logic [MW+1:0] diff_c  [1:RW];
    logic          fit_c   [1:RW];

    // one root bit per stage: bring down two radicand bits, try 4y+1
    always_comb begin
        for (int s = 1; s <= RW; s++) begin
            try_c[s]   = {rem_reg[s-1], rad_reg[s-1][RAD_W-1 -: 2]};
            trial_c[s] = {2'b00, root_reg[s-1], 2'b01};
            fit_c[s]   = try_c[s] >= trial_c[s];
            diff_c[s]  = try_c[s] - trial_c[s];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= RW; s++) begin
                val_reg[s] <= 1'b0;
            end
        end else if (en) begin
            val_reg[0] <= in_valid;
            for (int s = 1; s <= RW; s++) begin
                val_reg[s] <= val_reg[s-1];
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int s = 1; s <= RW; s++) begin
                rad_reg[s]  <= rad_reg[s-1] << 2;
                rem_reg[s]  <= fit_c[s] ? diff_c[s][MW-1:0] : try_c[s][MW-1:0];
                root_reg[s] <= {root_reg[s-1][RW-2:0], fit_c[s]};
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = val_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

[rtl/bbme_div.sv]
`timescale 1ns / 1ps
module bbme_div #(
    parameter int NUM_W  = 66,
    parameter int DEN_W  = 33,
    parameter int QW     = 32,
    parameter int SIDE_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quo,
    output logic [SIDE_W-1:0] out_side
);
    // quotient must fit QW bits: num < den * 2^QW
    localparam int CW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic              val_reg  [0:QW];
    logic [SIDE_W-1:0] side_reg [0:QW];
    logic [NUM_W-1:0]  rem_reg  [0:QW];
    logic [DEN_W-1:0]  den_reg  [0:QW];
    logic [QW-1:0]     quo_reg  [0:QW];

    logic [CW-1:0] sh_c  [1:QW];
    logic [CW-1:0] dif_c [1:QW];
    logic          fit_c [1:QW];

    // restoring step: quotient bit QW-s in stage s
    always_comb begin
        for (int s = 1; s <= QW; s++) begin
            sh_c[s]  = CW'(den_reg[s-1]) << (QW - s);
            fit_c[s] = CW'(rem_reg[s-1]) >= sh_c[s];
            dif_c[s] = CW'(rem_reg[s-1]) - sh_c[s];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= QW; s++) begin
                val_reg[s] <= 1'b0;
            end
        end else if (en) begin
            val_reg[0] <= in_valid;
            for (int s = 1; s <= QW; s++) begin
                val_reg[s] <= val_reg[s-1];
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
            for (int s = 1; s <= QW; s++) begin
                rem_reg[s]  <= fit_c[s] ? dif_c[s][NUM_W-1:0] : rem_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                quo_reg[s]  <= {quo_reg[s-1][QW-2:0], fit_c[s]};
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = val_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

[rtl/bernstein_breakup_momentum_eval_top.sv]
`timescale 1ns / 1ps
// Breakup-momentum Bernstein density evaluator.
// Input channel s_*: one parent mass per word (unsigned Q4.28 GeV).
// Result channel m_*: one word per input, density (signed Q16.24) and status
// (ok, zero parent mass, empty momentum range; the last two give density 0).
// Daughter masses, momentum range, coefficients: APB, byte address 4*index.
// The user must write them only while no word is in flight (not enforced).
// Throughput: one word per cycle while the output is not stalled. The pipeline
// holds 138 + DEGREE register stages between s_* and m_*.
// The stages: four for the kallen product, 67 for the bitwise square root,
// 33 for the division by 2m, 31 for the division by the momentum span, one
// selecting t, DEGREE basis multiplies, one coefficient multiply and the
// output register.
// The pipeline moves as a whole: when m_valid is high and m_ready low, every
// stage holds and s_ready is low; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: zero masses, q range 0 to 1.0, zero coefficients.
module bernstein_breakup_momentum_eval_top #(
    parameter int DEGREE = bbme_pkg::DEGREE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bbme_pkg::MASS_W-1:0]  s_mass,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bbme_pkg::DENS_W-1:0]  m_density,
    output logic [bbme_pkg::STAT_W-1:0]  m_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbme_pkg::ADDR_W-1:0]  paddr,
    input  logic [bbme_pkg::DATA_W-1:0]  pwdata,
    output logic [bbme_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import bbme_pkg::*;

    localparam int SIDE_W = MASS_W + STAT_W;

    // configuration registers
    logic [MASS_W-1:0]        mass_a_reg;
    logic [MASS_W-1:0]        mass_b_reg;
    logic [MASS_W-1:0]        q_min_reg;
    logic [MASS_W-1:0]        q_max_reg;
    logic signed [COEF_W-1:0] coef_reg [0:MAX_DEGREE];
    logic [IDX_W-1:0]         cfg_idx;
    logic                     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_a_reg <= '0;
            mass_b_reg <= '0;
            q_min_reg  <= '0;
            q_max_reg  <= MASS_W'(32'h1000_0000);
            for (int i = 0; i <= MAX_DEGREE; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MASS_A: mass_a_reg  <= pwdata;
                REG_MASS_B: mass_b_reg  <= pwdata;
                REG_Q_MIN:  q_min_reg   <= pwdata;
                REG_Q_MAX:  q_max_reg   <= pwdata;
                REG_COEF_0: coef_reg[0] <= pwdata;
                REG_COEF_1: coef_reg[1] <= pwdata;
                REG_COEF_2: coef_reg[2] <= pwdata;
                REG_COEF_3: coef_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_MASS_A: prdata = mass_a_reg;
            REG_MASS_B: prdata = mass_b_reg;
            REG_Q_MIN:  prdata = q_min_reg;
            REG_Q_MAX:  prdata = q_max_reg;
            REG_COEF_0: prdata = coef_reg[0];
            REG_COEF_1: prdata = coef_reg[1];
            REG_COEF_2: prdata = coef_reg[2];
            REG_COEF_3: prdata = coef_reg[3];
            default:    prdata = '0;
        endcase
    end

    // derived constants of the configuration
    logic [MASS_W:0]   sum_ab;
    logic [MASS_W-1:0] dif_ab;
    logic              range_empty;
    logic [MASS_W-1:0] q_span;

    assign sum_ab      = {1'b0, mass_a_reg} + {1'b0, mass_b_reg};
    assign dif_ab      = (mass_a_reg > mass_b_reg) ? mass_a_reg - mass_b_reg
                                                   : mass_b_reg - mass_a_reg;
    assign range_empty = q_max_reg <= q_min_reg;
    assign q_span      = q_max_reg - q_min_reg;

    // global pipeline advance
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 0: mass sums and differences, status
    logic              v0_reg;
    logic [MASS_W-1:0] m0_reg;
    logic [STAT_W-1:0] st0_reg;
    logic [MASS_W:0]   e1_reg;
    logic [MASS_W+1:0] f1_reg;
    logic [MASS_W-1:0] e2_reg;
    logic [MASS_W:0]   f2_reg;
    logic [MASS_W:0]   m_ext;
    logic [STAT_W-1:0] st0_next;

    assign m_ext = {1'b0, s_mass};

    always_comb begin
        if (s_mass == '0) begin
            st0_next = STAT_ZERO_MASS;
        end else if (range_empty) begin
            st0_next = STAT_EMPTY_RANGE;
        end else begin
            st0_next = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_reg  <= s_mass;
            st0_reg <= st0_next;
            e1_reg  <= (m_ext > sum_ab) ? m_ext - sum_ab : sum_ab - m_ext;
            f1_reg  <= {1'b0, m_ext} + {1'b0, sum_ab};
            e2_reg  <= (s_mass > dif_ab) ? s_mass - dif_ab : dif_ab - s_mass;
            f2_reg  <= m_ext + {1'b0, dif_ab};
        end
    end

    // stage 1: the two kallen factors
    logic         v1_reg;
    logic [SIDE_W-1:0] sd1_reg;
    logic [66:0]  k1_reg;
    logic [64:0]  k2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd1_reg <= {m0_reg, st0_reg};
            k1_reg  <= 67'(e1_reg) * 67'(f1_reg);
            k2_reg  <= 65'(e2_reg) * 65'(f2_reg);
        end
    end

    // stage 2: partial products of the factor product
    logic         v2_reg;
    logic [SIDE_W-1:0] sd2_reg;
    logic [66:0]  pll_reg;
    logic [65:0]  plh_reg;
    logic [65:0]  phl_reg;
    logic [64:0]  phh_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd2_reg <= sd1_reg;
            pll_reg <= 67'(k1_reg[33:0])  * 67'(k2_reg[32:0]);
            plh_reg <= 66'(k1_reg[33:0])  * 66'(k2_reg[64:33]);
            phl_reg <= 66'(k1_reg[66:34]) * 66'(k2_reg[32:0]);
            phh_reg <= 65'(k1_reg[66:34]) * 65'(k2_reg[64:33]);
        end
    end

    // stage 3: radicand
    logic              v3_reg;
    logic [SIDE_W-1:0] sd3_reg;
    logic [RAD_W-1:0]  rad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd3_reg <= sd2_reg;
            rad_reg <= RAD_W'(pll_reg) + (RAD_W'(plh_reg) << 33)
                     + (RAD_W'(phl_reg) << 34) + (RAD_W'(phh_reg) << 67);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // square root of the kallen product
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic [SIDE_W-1:0] sq_side_in;

    assign sq_side_in = sd3_reg;

    bbme_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (rad_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // root / 2m, saturating when the quotient passes 32 bits
    logic [MASS_W:0]   two_m;
    logic              q_sat;
    logic [ROOT_W-1:0] d1_num;
    logic              d1_valid;
    logic [MASS_W-1:0] d1_quo;
    logic [STAT_W:0]   d1_side;

    assign two_m  = {sq_side[SIDE_W-1:STAT_W], 1'b0};
    assign q_sat  = sq_root[ROOT_W-1:MASS_W] >= {1'b0, two_m};
    assign d1_num = q_sat ? '0 : sq_root;

    bbme_div #(
        .NUM_W  (ROOT_W),
        .DEN_W  (MASS_W + 1),
        .QW     (MASS_W),
        .SIDE_W (STAT_W + 1)
    ) u_div_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (d1_num),
        .in_den    (two_m),
        .in_side   ({sq_side[STAT_W-1:0], q_sat}),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    // map q onto the range: clamp or divide by the span
    logic [MASS_W-1:0]        q_val;
    logic [1:0]               tsel;
    logic [MASS_W+FRAC_W-1:0] d2_num;
    logic                     d2_valid;
    logic [FRAC_W-1:0]        d2_quo;
    logic [STAT_W+1:0]        d2_side;

    assign q_val = d1_side[0] ? '1 : d1_quo;

    always_comb begin
        if (q_val <= q_min_reg) begin
            tsel = TSEL_ZERO;
        end else if (q_val >= q_max_reg) begin
            tsel = TSEL_ONE;
        end else begin
            tsel = TSEL_DIV;
        end
    end

    assign d2_num = (tsel == TSEL_DIV) ? {q_val - q_min_reg, FRAC_W'(0)} : '0;

    bbme_div #(
        .NUM_W  (MASS_W + FRAC_W),
        .DEN_W  (MASS_W),
        .QW     (FRAC_W),
        .SIDE_W (STAT_W + 2)
    ) u_div_t (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d1_valid),
        .in_num    (d2_num),
        .in_den    (q_span),
        .in_side   ({d1_side[STAT_W:1], tsel}),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    // basis stages: stage 0 holds t, u and p = 1 for every index
    logic                bv_reg [0:DEGREE];
    logic [UNIT_W-1:0]   bt_reg [0:DEGREE];
    logic [UNIT_W-1:0]   bu_reg [0:DEGREE];
    logic [STAT_W-1:0]   bs_reg [0:DEGREE];
    logic [UNIT_W-1:0]   bp_reg [0:DEGREE][0:DEGREE];
    logic [UNIT_W-1:0]   t_next;
    logic [2*UNIT_W-2:0] prod_c [0:DEGREE][0:DEGREE];

    always_comb begin
        case (d2_side[1:0])
            TSEL_ZERO: t_next = '0;
            TSEL_ONE:  t_next = ONE_Q30;
            default:   t_next = {1'b0, d2_quo};
        endcase
    end

    // multiply step j: indexes above j take t, the rest take u
    always_comb begin
        for (int j = 0; j <= DEGREE; j++) begin
            for (int i = 0; i <= DEGREE; i++) begin
                prod_c[j][i] = (2*UNIT_W-1)'(bp_reg[j][i])
                             * (2*UNIT_W-1)'((j < i) ? bt_reg[j] : bu_reg[j])
                             + (2*UNIT_W-1)'(HALF_Q30);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= DEGREE; j++) begin
                bv_reg[j] <= 1'b0;
            end
        end else if (en) begin
            bv_reg[0] <= d2_valid;
            for (int j = 1; j <= DEGREE; j++) begin
                bv_reg[j] <= bv_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bt_reg[0] <= t_next;
            bu_reg[0] <= ONE_Q30 - t_next;
            bs_reg[0] <= d2_side[STAT_W+1:2];
            for (int i = 0; i <= DEGREE; i++) begin
                bp_reg[0][i] <= ONE_Q30;
            end
            for (int j = 1; j <= DEGREE; j++) begin
                bt_reg[j] <= bt_reg[j-1];
                bu_reg[j] <= bu_reg[j-1];
                bs_reg[j] <= bs_reg[j-1];
                for (int i = 0; i <= DEGREE; i++) begin
                    bp_reg[j][i] <= prod_c[j-1][i][2*UNIT_W-2:FRAC_W];
                end
            end
        end
    end

    // coefficient terms: coef_i * C(n,i) * p_i
    localparam int TERM_W = COEF_W + MASS_W + 1;
    logic                     tv_reg;
    logic [STAT_W-1:0]        ts_reg;
    logic signed [TERM_W-1:0] tm_reg [0:DEGREE];
    logic [MASS_W+1:0]        scaled_c [0:DEGREE];
    logic signed [MASS_W:0]   sc_c [0:DEGREE];

    always_comb begin
        for (int i = 0; i <= DEGREE; i++) begin
            scaled_c[i] = (MASS_W+2)'(bp_reg[DEGREE][i])
                        * (MASS_W+2)'(binom(DEGREE, i));
            sc_c[i]     = $signed({1'b0, scaled_c[i][MASS_W-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else if (en) begin
            tv_reg <= bv_reg[DEGREE];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ts_reg <= bs_reg[DEGREE];
            for (int i = 0; i <= DEGREE; i++) begin
                tm_reg[i] <= TERM_W'(coef_reg[i]) * TERM_W'(sc_c[i]);
            end
        end
    end

    // sum, round to Q16.24 and output register
    localparam int SUM_W = TERM_W + 2;
    logic signed [SUM_W-1:0]  sum_c;
    logic signed [SUM_W-1:0]  shr_c;
    logic [DENS_W-1:0]        density_next;
    logic [DENS_W-1:0]        m_density_reg;
    logic [STAT_W-1:0]        m_status_reg;

    always_comb begin
        sum_c = $signed({(SUM_W-UNIT_W)'(0), HALF_Q30});
        for (int i = 0; i <= DEGREE; i++) begin
            sum_c = sum_c + SUM_W'(tm_reg[i]);
        end
        shr_c        = sum_c >>> FRAC_W;
        density_next = (ts_reg == STAT_OK) ? shr_c[DENS_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= tv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_density_reg <= density_next;
            m_status_reg  <= ts_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_density = m_density_reg;
    assign m_status  = m_status_reg;

    // checks
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != STAT_OK |-> m_density_reg == '0)
        else $error("density not zero on a fault status");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

    a_t_plus_u: assert property (@(posedge aclk) disable iff (!aresetn)
        bv_reg[0] |-> (bt_reg[0] + bu_reg[0]) == ONE_Q30)
        else $error("t and 1-t do not add to one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(tv_reg) && $stable(ts_reg))
        else $error("pipeline moved during a stall");

endmodule
